// ===== hw/rtl/ffha_pkg.sv =====
// Package: shared types, codes and constants for the first-fit heap allocator.
package ffha_pkg;

   localparam int MEM_WORDS_DEF = 4096;

   // Header word layout
   localparam logic [15:0] HDR_FREE = 16'h8000;
   localparam logic [15:0] HDR_REF1 = 16'h0200;
   localparam logic [8:0]  BLK_MAX  = 9'd256;
   localparam logic [15:0] REQ_MAX  = 16'd512;

   typedef enum logic {
      FUNC_FORMAT = 1'b0,
      FUNC_ALLOC  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_TOO_BIG = 2'd1,
      STAT_NO_FIT  = 2'd2
   } status_type;

   typedef enum logic {
      REG_HEAP_BASE  = 1'b0,
      REG_HEAP_LIMIT = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FMT,
      ST_RD,
      ST_HDR,
      ST_NXT,
      ST_SPLIT,
      ST_MERGE,
      ST_DONE
   } state_type;

   typedef struct packed {
      func_type    func;
      logic [15:0] size_bytes;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [12:0] data_addr;
   } rsp_type;

endpackage

// ===== hw/rtl/first_fit_heap_allocator.sv =====
// Top level: first-fit heap allocator with block coalescing over a word RAM.
// Operation: format writes one free header per block; allocate reads and checks each
//   header walked, reads a free header's neighbor, writes a split or capped-merge tail,
//   re-reads a merged header, ends with no fit if the walk runs off the end, then hands off.
// Requests: one at a time, busy until the result is handed off; oversized requests skip the walk.
// Reset: synchronous, active high; idle, result valid low, heap base 0, limit 4095; RAM undefined.
module first_fit_heap_allocator
   import ffha_pkg::*;
#(
   parameter int MEM_WORDS = MEM_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_item,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_item,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = $clog2(MEM_WORDS);

   // Walk addresses are 13 bits; RAM access wraps modulo the RAM depth.
   function automatic logic [AW-1:0] ram_addr(input logic [12:0] a);
      logic [AW+12:0] ext;
      ext = {{AW{1'b0}}, a};
      return ext[AW-1:0];
   endfunction

   // ---------------------------------------------------------------- registers
   state_type   state_ff, state_in;
   logic [11:0] heap_base_ff, heap_base_in;
   logic [11:0] heap_limit_ff, heap_limit_in;
   logic [12:0] cur_ff, cur_in;        // header address (format: next header)
   logic [12:0] left_ff, left_in;      // format: words still to cover
   logic [8:0]  words_ff, words_in;    // allocation size in words
   logic [15:0] hdr_ff, hdr_in;        // current header, held for merge check
   logic [12:0] pend_addr_ff, pend_addr_in;  // deferred second write
   logic [15:0] pend_data_ff, pend_data_in;
   status_type  res_status_ff, res_status_in;
   logic [12:0] res_addr_ff, res_addr_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_item_ff, rsp_item_in;

   // ---------------------------------------------------------------- RAM port
   logic          mem_wr_en;
   logic [12:0]   mem_wr_addr;
   logic [15:0]   mem_wr_data;
   logic          mem_rd_en;
   logic [12:0]   mem_rd_addr;
   logic [15:0]   mem_rd_data;

   ffha_ram #(
      .WIDTH (16),
      .DEPTH (MEM_WORDS)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (ram_addr(mem_wr_addr)),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (ram_addr(mem_rd_addr)),
      .rd_data (mem_rd_data)
   );

   // ---------------------------------------------------------------- handshakes
   logic req_take;
   logic rsp_free;
   logic cfg_wr;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (reg_index_type'(csr_paddr[2]))
         REG_HEAP_BASE:  csr_prdata = {20'd0, heap_base_ff};
         REG_HEAP_LIMIT: csr_prdata = {20'd0, heap_limit_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------- datapath terms
   logic [12:0] heap_limit13;
   logic [16:0] size_p1;
   logic [8:0]  req_words;
   logic [12:0] fmt_left;
   logic [12:0] left_m1;
   logic [8:0]  chunk;
   logic [8:0]  have;          // size of current header as read
   logic        fits;
   logic [8:0]  rest;
   logic [12:0] cur_p1;
   logic [12:0] nxt_rd;        // next header from freshly read header
   logic [12:0] nxt_held;      // next header from held header
   logic [9:0]  merged;
   logic [9:0]  merged_rest;

   assign heap_limit13 = {1'b0, heap_limit_ff};
   assign size_p1      = {1'b0, req_item.size_bytes} + 17'd1;
   assign req_words    = size_p1[9:1];
   assign fmt_left     = heap_limit13 - {1'b0, heap_base_ff} + 13'd1;
   assign left_m1      = left_ff - 13'd1;
   assign chunk        = (left_m1 > {4'd0, BLK_MAX}) ? BLK_MAX : left_m1[8:0];
   assign have         = mem_rd_data[8:0];
   assign fits         = mem_rd_data[15] && (have >= words_ff);
   assign rest         = have - words_ff;
   assign cur_p1       = cur_ff + 13'd1;
   assign nxt_rd       = cur_p1 + {4'd0, have};
   assign nxt_held     = cur_p1 + {4'd0, hdr_ff[8:0]};
   assign merged       = {1'b0, hdr_ff[8:0]} + 10'd1 + {1'b0, mem_rd_data[8:0]};
   assign merged_rest  = merged - 10'd257;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_item.func == FUNC_FORMAT) begin
                  state_in = (heap_base_ff > heap_limit_ff) ? ST_DONE : ST_FMT;
               end else if (req_item.size_bytes > REQ_MAX) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_FMT: begin
            if (left_m1 == {4'd0, chunk}) begin
               state_in = ST_DONE;
            end
         end
         ST_RD: begin
            state_in = (cur_ff > heap_limit13) ? ST_DONE : ST_HDR;
         end
         ST_HDR: begin
            if (fits) begin
               state_in = (rest == 9'd0) ? ST_DONE : ST_SPLIT;
            end else if (mem_rd_data[15] && (nxt_rd <= heap_limit13)) begin
               state_in = ST_NXT;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_NXT: begin
            if (mem_rd_data[15] && (merged > {1'b0, BLK_MAX})) begin
               state_in = ST_MERGE;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_SPLIT: state_in = ST_DONE;
         ST_MERGE: state_in = ST_RD;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- RAM control
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = cur_ff;
      mem_wr_data = 16'd0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = cur_ff;
      case (state_ff)
         ST_FMT: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = {7'd0, chunk} | HDR_FREE;
         end
         ST_RD: begin
            mem_rd_en = (cur_ff <= heap_limit13);
         end
         ST_HDR: begin
            if (fits) begin
               mem_wr_en   = 1'b1;
               // exact fit keeps the stored size, otherwise shrink to request
               mem_wr_data = (rest == 9'd0) ? ({7'd0, have} | HDR_REF1)
                                            : ({7'd0, words_ff} | HDR_REF1);
            end else if (mem_rd_data[15] && (nxt_rd <= heap_limit13)) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = nxt_rd;
            end
         end
         ST_NXT: begin
            if (mem_rd_data[15]) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = (merged > {1'b0, BLK_MAX}) ? ({7'd0, BLK_MAX} | HDR_FREE)
                                                        : ({6'd0, merged} | HDR_FREE);
            end
         end
         ST_SPLIT, ST_MERGE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = pend_addr_ff;
            mem_wr_data = pend_data_ff;
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      heap_base_in  = heap_base_ff;
      heap_limit_in = heap_limit_ff;
      cur_in        = cur_ff;
      left_in       = left_ff;
      words_in      = words_ff;
      hdr_in        = hdr_ff;
      pend_addr_in  = pend_addr_ff;
      pend_data_in  = pend_data_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_item_in   = rsp_item_ff;

      if (cfg_wr) begin
         case (reg_index_type'(csr_paddr[2]))
            REG_HEAP_BASE:  heap_base_in  = csr_pwdata[11:0];
            REG_HEAP_LIMIT: heap_limit_in = csr_pwdata[11:0];
            default:        heap_base_in  = heap_base_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cur_in        = {1'b0, heap_base_ff};
               left_in       = fmt_left;
               words_in      = req_words;
               res_status_in = STAT_OK;
               res_addr_in   = 13'd0;
               if (req_item.func == FUNC_ALLOC && req_item.size_bytes > REQ_MAX) begin
                  res_status_in = STAT_TOO_BIG;
               end
            end
         end
         ST_FMT: begin
            cur_in  = cur_p1 + {4'd0, chunk};
            left_in = left_m1 - {4'd0, chunk};
         end
         ST_RD: begin
            if (cur_ff > heap_limit13) begin
               res_status_in = STAT_NO_FIT;
            end
         end
         ST_HDR: begin
            hdr_in = mem_rd_data;
            if (fits) begin
               res_addr_in  = cur_p1;
               pend_addr_in = cur_p1 + {4'd0, words_ff};
               pend_data_in = {7'd0, rest - 9'd1} | HDR_FREE;
            end else if (!(mem_rd_data[15] && (nxt_rd <= heap_limit13))) begin
               cur_in = nxt_rd;
            end
         end
         ST_NXT: begin
            if (mem_rd_data[15]) begin
               // merged block capped at BLK_MAX; excess becomes a free block
               pend_addr_in = cur_p1 + {4'd0, BLK_MAX};
               pend_data_in = {6'd0, merged_rest} | HDR_FREE;
            end else begin
               cur_in = nxt_held;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in          = 1'b1;
               rsp_item_in.status    = res_status_ff;
               rsp_item_in.data_addr = res_addr_ff;
            end
         end
         default: begin
            cur_in = cur_ff;
         end
      endcase
   end

   // ---------------------------------------------------------------- flops
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         heap_base_ff  <= 12'd0;
         heap_limit_ff <= 12'd4095;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         heap_base_ff  <= heap_base_in;
         heap_limit_ff <= heap_limit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      left_ff       <= left_in;
      words_ff      <= words_in;
      hdr_ff        <= hdr_in;
      pend_addr_ff  <= pend_addr_in;
      pend_data_ff  <= pend_data_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_item_ff   <= rsp_item_in;
   end

endmodule

// ===== hw/rtl/ffha_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
module ffha_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ffha_checker.sv =====
// Checker: port-level assertions for the heap allocator, bound to the top level.
module ffha_checker
   import ffha_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_item,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_item
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   // one request at a time: taking an item makes the block busy
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request channel open right after an item was taken");

   // a fresh result only comes out of a busy block
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared with no request in progress");

   // failures never carry an address
   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status != STAT_OK) |-> rsp_item.data_addr == 13'd0)
      else $error("failed request returned an address");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);

// ===== dv/first_fit_heap_allocator_tb.sv =====
// Self-checking testbench for the first-fit heap allocator: directed plan, then random phases.
module first_fit_heap_allocator_tb;
   import ffha_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Header size field; free flag and ref-count-one come from the package.
   localparam int unsigned SIZE_MASK    = 32'h0000_01FF;
   localparam int          IDX_W        = $clog2(MEM_WORDS_DEF);
   localparam int unsigned RAND_ITEMS   = 1400;
   // Worst case: walks of ~50 headers, merges and idle gaps per item,
   // over ~1450 items, then taken about ten times over.
   localparam int unsigned CYCLE_LIMIT  = 3000000;
   localparam int unsigned SETTLE_CYC   = 4;
   localparam int unsigned TAIL_CYC     = 40;

   // Directed plan: register setup, or one item checked against a typed
   // value or against the predictor.
   typedef enum logic [1:0] {
      ROW_SETUP,
      ROW_TYPED,
      ROW_PREDICTED
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      func_type     func;
      logic [15:0]  size;
      status_type   status;
      logic [12:0]  addr;
      logic [11:0]  lo;
      logic [11:0]  hi;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_item;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_item;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predictor state: heap image and the range registers as last written.
   logic [15:0] heap_img [MEM_WORDS_DEF];
   logic [11:0] heap_lo = 12'd0;
   logic [11:0] heap_hi = 12'd4095;

   rsp_type outcomes_due [$];   // one entry per accepted item, oldest first
   int      errors  = 0;
   bit      no_idle = 1'b0;     // phase-wide switch: both sides run without gaps

   first_fit_heap_allocator dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   // Memory wraps at MEM_WORDS, same as the block's RAM.
   function automatic logic [15:0] heap_rd(input int unsigned a);
      return heap_img[IDX_W'(a % MEM_WORDS_DEF)];
   endfunction

   function automatic void heap_wr(input int unsigned a, input int unsigned v);
      heap_img[IDX_W'(a % MEM_WORDS_DEF)] = v[15:0];
   endfunction

   // Format: chain of free blocks, each at most BLK_MAX data words.
   function automatic void carve_heap();
      int unsigned at, left, chunk, hdr;
      if (heap_lo > heap_hi) return;   // inverted range writes nothing
      at   = 32'(heap_lo);
      left = heap_hi - heap_lo + 1;
      while (left != 0) begin
         hdr   = at;
         at    = at + 1;
         left  = left - 1;
         chunk = (left > int'(BLK_MAX)) ? int'(BLK_MAX) : left;
         heap_wr(hdr, chunk | HDR_FREE);
         at    = at + chunk;
         left  = left - chunk;
      end
   endfunction

   // First-fit walk with on-the-fly coalescing; returns data address or 0.
   function automatic int unsigned claim_first_fit(input int unsigned words);
      int unsigned cur, h, have, nxt, rest, merged;
      bit          nfree;
      cur = 32'(heap_lo);
      while (1'b1) begin
         if (cur > heap_hi) return 0;
         h    = 32'(heap_rd(cur));
         have = h & SIZE_MASK;
         if ((h & HDR_FREE) != 0 && have >= words) begin
            rest = have - words;
            if (rest == 0) begin
               heap_wr(cur, have | HDR_REF1);
            end else begin
               heap_wr(cur, words | HDR_REF1);
               heap_wr(cur + 1 + words, HDR_FREE | (rest - 1));
            end
            return cur + 1;
         end
         nxt = cur + 1 + have;
         // a neighbor header beyond the heap limit never counts as free
         nfree = (nxt <= heap_hi) && ((heap_rd(nxt) & HDR_FREE) != 0);
         if ((h & HDR_FREE) != 0 && nfree) begin
            merged = have + 1 + (heap_rd(nxt) & SIZE_MASK);
            if (merged > int'(BLK_MAX)) begin
               // cap at BLK_MAX, excess becomes its own free block
               heap_wr(cur + 1 + int'(BLK_MAX), (merged - int'(BLK_MAX) - 1) | HDR_FREE);
               merged = 32'(BLK_MAX);
            end
            heap_wr(cur, merged | HDR_FREE);
         end else begin
            cur = nxt;
         end
      end
      return 0;
   endfunction

   function automatic rsp_type alloc_outcome(input req_type it);
      rsp_type     o;
      int unsigned a;
      o.status    = STAT_OK;
      o.data_addr = '0;
      if (it.func == FUNC_FORMAT) begin
         carve_heap();
      end else if (it.size_bytes > REQ_MAX) begin
         o.status = STAT_TOO_BIG;
      end else begin
         a = claim_first_fit((int'(it.size_bytes) + 1) >> 1);   // bytes to words
         if (a == 0) o.status = STAT_NO_FIT;
         else        o.data_addr = a[12:0];
      end
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   function automatic int idle_draw();
      return no_idle ? 0 : $urandom_range(0, 3);
   endfunction

   // One item: optional gap, then hold valid until accepted. With no gap,
   // valid stays high and only the payload moves.
   task automatic send_req(input req_type it, input bit use_typed, input rsp_type typed_rsp);
      int      gap;
      rsp_type outcome;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      outcome = alloc_outcome(it);   // predictor advances in acceptance order
      outcomes_due.push_back(use_typed ? typed_rsp : outcome);
   endtask

   // Wait until every result is back and the block has settled.
   task automatic drain();
      req_valid <= 1'b0;
      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // APB write (setup + access), then read back through the same port.
   task automatic csr_write_check(input reg_index_type idx, input logic [11:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {20'd0, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[11:0] !== val) begin
         $display("%0t ns: reg %s read expected %0d, got %0d",
                  $time, idx.name(), val, csr_prdata[11:0]);
         errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (idx == REG_HEAP_BASE) heap_lo = val;
      else                      heap_hi = val;
   endtask

   // Range change only while idle; write order is random.
   task automatic set_range(input logic [11:0] lo, input logic [11:0] hi);
      drain();
      if ($urandom_range(0, 1) == 1) begin
         csr_write_check(REG_HEAP_BASE, lo);
         csr_write_check(REG_HEAP_LIMIT, hi);
      end else begin
         csr_write_check(REG_HEAP_LIMIT, hi);
         csr_write_check(REG_HEAP_BASE, lo);
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stall per item, stall counted only while a result
   // is offered so it lands on real results.
   // ---------------------------------------------------------------------
   initial begin : rsp_side
      rsp_type want;
      int      hold;
      hold = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (outcomes_due.size() == 0) begin
               $display("%0t ns: result with nothing due, got status %0d addr %0d",
                        $time, rsp_item.status, rsp_item.data_addr);
               errors++;
            end else begin
               want = outcomes_due.pop_front();
               if (rsp_item.status !== want.status) begin
                  $display("%0t ns: status expected %0d, got %0d",
                           $time, want.status, rsp_item.status);
                  errors++;
               end
               if (rsp_item.data_addr !== want.data_addr) begin
                  $display("%0t ns: data_addr expected %0d, got %0d",
                           $time, want.data_addr, rsp_item.data_addr);
                  errors++;
               end
            end
            hold = idle_draw();
         end else if (rsp_valid && hold > 0) begin
            hold--;
         end
         rsp_stall <= (hold > 0);
      end
   end

   // Cycle cap: a hung walk or lost handshake ends here.
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("first_fit_heap_allocator_tb: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      plan_row_type plan [26];
      plan_row_type r;
      req_type      it;
      rsp_type      typed_rsp;
      int unsigned  rand_count, pick, lo, hi, span, n;

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_item    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;

      // Reset range 0..4095: format gives 15 blocks of 256 words and a last
      // one of 240. Later rows: inverted range, single-word heap at the top
      // of memory (data address 4096, neighbor past the heap limit), single
      // word at 0, and a small heap where a split tail merges with its neighbor.
      plan = '{
         '{ROW_TYPED,     FUNC_FORMAT, 16'd0,     STAT_OK,      13'd0,    12'd0,    12'd0},
         '{ROW_TYPED,     FUNC_ALLOC,  16'd513,   STAT_TOO_BIG, 13'd0,    12'd0,    12'd0},
         '{ROW_TYPED,     FUNC_ALLOC,  16'hFFFF,  STAT_TOO_BIG, 13'd0,    12'd0,    12'd0},
         '{ROW_TYPED,     FUNC_ALLOC,  16'd512,   STAT_OK,      13'd1,    12'd0,    12'd0},
         '{ROW_PREDICTED, FUNC_ALLOC,  16'd0,     STAT_OK,      13'd0,    12'd0,    12'd0},
         '{ROW_PREDICTED, FUNC_ALLOC,  16'd1,     STAT_OK,      13'd0,    12'd0,    12'd0},
         '{ROW_PREDICTED, FUNC_ALLOC,  16'd504,   STAT_OK,      13'd0,    12'd0,    12'd0},
         '{ROW_PREDICTED, FUNC_ALLOC,  16'd0,     STAT_OK,      13'd0,    12'd0,    12'd0},
         '{ROW_PREDICTED, FUNC_ALLOC,  16'd2,     STAT_OK,      13'd0,    12'd0,    12'd0},
         '{ROW_PREDICTED, FUNC_ALLOC,  16'd512,   STAT_OK,      13'd0,    12'd0,    12'd0},
         '{ROW_TYPED,     FUNC_ALLOC,  16'h8000,  STAT_TOO_BIG, 13'd0,    12'd0,    12'd0},
         '{ROW_SETUP,     FUNC_FORMAT, 16'd0,     STAT_OK,      13'd0,    12'd4095, 12'd0},
         '{ROW_TYPED,     FUNC_FORMAT, 16'd0,     STAT_OK,      13'd0,    12'd0,    12'd0},
         '{ROW_TYPED,     FUNC_ALLOC,  16'd0,     STAT_NO_FIT,  13'd0,    12'd0,    12'd0},
         '{ROW_SETUP,     FUNC_FORMAT, 16'd0,     STAT_OK,      13'd0,    12'd4095, 12'd4095},
         '{ROW_TYPED,     FUNC_FORMAT, 16'd0,     STAT_OK,      13'd0,    12'd0,    12'd0},
         '{ROW_TYPED,     FUNC_ALLOC,  16'd2,     STAT_NO_FIT,  13'd0,    12'd0,    12'd0},
         '{ROW_TYPED,     FUNC_ALLOC,  16'd0,     STAT_OK,      13'd4096, 12'd0,    12'd0},
         '{ROW_SETUP,     FUNC_FORMAT, 16'd0,     STAT_OK,      13'd0,    12'd0,    12'd0},
         '{ROW_TYPED,     FUNC_FORMAT, 16'd0,     STAT_OK,      13'd0,    12'd0,    12'd0},
         '{ROW_TYPED,     FUNC_ALLOC,  16'd0,     STAT_OK,      13'd1,    12'd0,    12'd0},
         '{ROW_TYPED,     FUNC_ALLOC,  16'd0,     STAT_NO_FIT,  13'd0,    12'd0,    12'd0},
         '{ROW_SETUP,     FUNC_FORMAT, 16'd0,     STAT_OK,      13'd0,    12'd0,    12'd300},
         '{ROW_TYPED,     FUNC_FORMAT, 16'd0,     STAT_OK,      13'd0,    12'd0,    12'd0},
         '{ROW_TYPED,     FUNC_ALLOC,  16'd510,   STAT_OK,      13'd1,    12'd0,    12'd0},
         '{ROW_TYPED,     FUNC_ALLOC,  16'd60,    STAT_OK,      13'd257,  12'd0,    12'd0}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, at the reset register values until the first setup row
      foreach (plan[i]) begin
         r = plan[i];
         if (r.kind == ROW_SETUP) begin
            set_range(r.lo, r.hi);
         end else begin
            it.func             = r.func;
            it.size_bytes       = r.size;
            typed_rsp.status    = r.status;
            typed_rsp.data_addr = r.addr;
            send_req(it, r.kind == ROW_TYPED, typed_rsp);
         end
      end

      // Random phases: new range, format, then a run of allocations.
      // Every range change is followed by a format before any walk, so the
      // walk never reads a header that was never written.
      rand_count = 0;
      while (rand_count < RAND_ITEMS) begin
         no_idle = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            // inverted range
            hi = $urandom_range(0, 4094);
            lo = $urandom_range(hi + 1, 4095);
         end else if (pick < 16) begin
            // near-full memory
            lo = $urandom_range(0, 300);
            hi = $urandom_range(3700, 4095);
         end else begin
            lo   = $urandom_range(0, 4095);
            span = (pick < 30) ? $urandom_range(1, 700) : $urandom_range(1, 160);
            hi   = (lo + span - 1 > 4095) ? 4095 : lo + span - 1;
         end
         set_range(12'(lo), 12'(hi));

         // noise: oversized requests before the format, no heap access
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 2)) begin
               it.func       = FUNC_ALLOC;
               it.size_bytes = 16'($urandom_range(513, 65535));
               send_req(it, 1'b0, '0);
               rand_count++;
            end
         end

         it.func       = FUNC_FORMAT;
         it.size_bytes = 16'($urandom);
         send_req(it, 1'b0, '0);
         rand_count++;

         n = $urandom_range(4, 24);
         repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
               // reformat mid-phase, same range
               it.func = FUNC_FORMAT;
               it.size_bytes = 16'($urandom);
            end else begin
               it.func = FUNC_ALLOC;
               if (pick < 60)      it.size_bytes = 16'($urandom_range(0, 64));
               else if (pick < 80) it.size_bytes = 16'($urandom_range(0, 512));
               else if (pick < 88) it.size_bytes = ($urandom_range(0, 1) == 1) ? 16'd512 : 16'd0;
               else if (pick < 94) it.size_bytes = 16'($urandom_range(513, 65535));
               else                it.size_bytes = 16'($urandom);
            end
            send_req(it, 1'b0, '0);
            rand_count++;
         end
      end

      drain();
      no_idle = 1'b0;
      // trailing window: any stray result still gets flagged
      repeat (TAIL_CYC) @(posedge clock);
      if (errors == 0)
         $display("first_fit_heap_allocator_tb: done, clean");
      else
         $display("first_fit_heap_allocator_tb: done, errors");
      $finish;
   end

endmodule
